// ===== rtl/imuw_pkg.sv =====
// shared types and constants of the imu window motion energy gate
// no dependencies; every other file but imuw_ring refers to it by scoped names
package imuw_pkg;

  localparam int unsigned WINDOW_SAMPLES = 100;
  localparam int unsigned AXIS_COUNT     = 6;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SQ_W       = 32;  // one squared axis difference
  localparam int unsigned ENERGY_W   = 35;  // one step energy over all axes
  localparam int unsigned TOTAL_W    = 42;  // reported window total
  localparam int unsigned STRIDE_W   = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 42;

  localparam logic [TOTAL_W-1:0]  FLOOR_RESET  = TOTAL_W'(50000000);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(25);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_STRIDE  = 1'b1;

  // per-transaction control that travels down the pipeline
  typedef struct packed {
    logic has_diff;   // a previous sample exists, so a step energy enters the ring
    logic old_valid;  // the ring slot being replaced holds a written energy
    logic emit;       // this sample produces a result
  } stage_ctl_t;

endpackage

// ===== rtl/imuw_sample_if.sv =====
// valid/ready channel carrying one six-axis imu sample
// depends on imuw_pkg for the axis width
interface imuw_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [imuw_pkg::SAMPLE_W-1:0]  accel_x;
  logic signed [imuw_pkg::SAMPLE_W-1:0]  accel_y;
  logic signed [imuw_pkg::SAMPLE_W-1:0]  accel_z;
  logic signed [imuw_pkg::SAMPLE_W-1:0]  gyro_x;
  logic signed [imuw_pkg::SAMPLE_W-1:0]  gyro_y;
  logic signed [imuw_pkg::SAMPLE_W-1:0]  gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

// ===== rtl/imuw_result_if.sv =====
// valid/ready channel carrying one motion evaluation
// depends on imuw_pkg for the total width
interface imuw_result_if;
  logic                               valid;
  logic                               ready;
  logic [imuw_pkg::TOTAL_W-1:0]       motion_total;
  logic                               moving;

  modport source (output valid, motion_total, moving, input ready);
  modport sink   (input valid, motion_total, moving, output ready);
endinterface

// ===== rtl/imuw_lane.sv =====
// one axis lane: difference to the previous sample, squared and registered
// depends on imuw_pkg
module imuw_lane (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [imuw_pkg::SAMPLE_W-1:0] cur_i,
  input  logic signed [imuw_pkg::SAMPLE_W-1:0] prev_i,
  output logic        [imuw_pkg::SQ_W-1:0]     sq_o
);

  logic signed [imuw_pkg::SAMPLE_W:0]     diff;
  logic signed [2*imuw_pkg::SAMPLE_W+1:0] prod;
  logic        [imuw_pkg::SQ_W-1:0]       sq_q;

  always_comb begin
    diff = {cur_i[imuw_pkg::SAMPLE_W-1], cur_i} - {prev_i[imuw_pkg::SAMPLE_W-1], prev_i};
    prod = diff * diff;
  end

  // |diff| is at most 65535, so the square fits in 32 bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= prod[imuw_pkg::SQ_W-1:0];
    end
  end

  assign sq_o = sq_q;

endmodule

// ===== rtl/imuw_merge.sv =====
// merging stage: adds the lane squares into one step energy and registers it
// depends on imuw_pkg
module imuw_merge (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [imuw_pkg::SQ_W-1:0]      sq_i [imuw_pkg::AXIS_COUNT],
  input  imuw_pkg::stage_ctl_t           ctl_i,
  output logic [imuw_pkg::ENERGY_W-1:0]  sum_o,
  output logic [imuw_pkg::ENERGY_W-1:0]  energy_o,
  output imuw_pkg::stage_ctl_t           ctl_o
);

  logic [imuw_pkg::ENERGY_W-1:0] sum;
  logic [imuw_pkg::ENERGY_W-1:0] energy_q;
  imuw_pkg::stage_ctl_t          ctl_q;

  always_comb begin
    sum = '0;
    for (int unsigned a = 0; a < imuw_pkg::AXIS_COUNT; a++) begin
      sum = sum + imuw_pkg::ENERGY_W'(sq_i[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      energy_q <= sum;
      ctl_q    <= ctl_i;
    end
  end

  assign sum_o    = sum;
  assign energy_o = energy_q;
  assign ctl_o    = ctl_q;

endmodule

// ===== rtl/imuw_ring.sv =====
// ring of step energies: one port, written and read at the same slot,
// read data registered and giving the value from before the write
module imuw_ring #(
  parameter int unsigned DEPTH  = 99,
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned DATA_W = 35
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/imu_window_motion_energy_gate_unit.sv =====
// imu window motion energy gate, top level
// uses imuw_pkg, imuw_sample_if, imuw_result_if, imuw_lane, imuw_merge, imuw_ring
//
// sample_i takes one six-axis sample per transaction, result_o gives one
// motion evaluation per transaction; both are valid/ready. cfg_we_i writes
// the energy limit (index 0) or eval_stride (index 1) from cfg_data_i; the user must
// write only while idle, as the block does not enforce it. Each axis has its own lane
// that forms the squared difference to the previous sample; a merge stage adds them
// into the step energy, which replaces the oldest entry of a (WINDOW_SAMPLES-1)-deep
// ring while a running total is updated. Once WINDOW_SAMPLES samples have arrived,
// every eval_stride-th sample yields a result: the total and whether it reaches the
// energy limit. Throughput: one sample per cycle, set by the single-port ring that is
// read and written in the same cycle, unless a stalled result backs up the pipeline.
// A result is formed through the lane, merge and ring, total and output registers.
// Reset clears the total and counters and restores the configuration defaults; the
// ring needs no clearing pass since a slot is only used after the fill count shows
// it was written. A stalled result holds the output register; samples keep entering
// and stop once the next result waits in stage 2 with the stages behind it full.
module imu_window_motion_energy_gate_unit #(
  parameter int unsigned WINDOW_SAMPLES = imuw_pkg::WINDOW_SAMPLES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  imuw_sample_if.sink                         sample_i,
  imuw_result_if.source                       result_o,
  input  logic                                cfg_we_i,
  input  logic [imuw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [imuw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned RingDepth = WINDOW_SAMPLES - 1;
  localparam int unsigned PtrW      = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned SeenW     = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned TotW      = imuw_pkg::ENERGY_W + $clog2(RingDepth);
  localparam int unsigned CmpW      = (TotW > imuw_pkg::TOTAL_W) ? TotW : imuw_pkg::TOTAL_W;
  localparam int unsigned SW        = imuw_pkg::SAMPLE_W;

  // configuration
  logic [imuw_pkg::TOTAL_W-1:0]  floor_q;
  logic [imuw_pkg::STRIDE_W-1:0] stride_cfg_q;

  // accept-side state
  logic signed [SW-1:0]          prev_q [imuw_pkg::AXIS_COUNT];
  logic signed [SW-1:0]          cur [imuw_pkg::AXIS_COUNT];
  logic [SeenW-1:0]              seen_q, seen_d;
  logic [imuw_pkg::STRIDE_W-1:0] stride_q, stride_d, stride_inc;
  logic [PtrW-1:0]               ptr_q, ptr_d;
  logic                          full;
  imuw_pkg::stage_ctl_t          ctl_in;

  // pipeline
  logic                          v0_q, v1_q, v2_q, out_valid_q;
  logic                          in_acc, adv0, adv1, adv2, s0_free, s1_free, s2_free;
  imuw_pkg::stage_ctl_t          ctl0_q, ctl1;
  logic [PtrW-1:0]               ptr0_q;
  logic [imuw_pkg::SQ_W-1:0]     sq0 [imuw_pkg::AXIS_COUNT];
  logic [imuw_pkg::ENERGY_W-1:0] sum0, energy1, old1;
  logic [TotW-1:0]               total_q, total_d;
  logic                          emit2_q;
  logic [CmpW-1:0]               tot_cmp;
  logic [imuw_pkg::TOTAL_W-1:0]  out_total_q;
  logic                          out_moving_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q      <= imuw_pkg::FLOOR_RESET;
      stride_cfg_q <= imuw_pkg::STRIDE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        imuw_pkg::CFG_ENERGY_LIMIT: floor_q      <= cfg_data_i[imuw_pkg::TOTAL_W-1:0];
        imuw_pkg::CFG_EVAL_STRIDE:  stride_cfg_q <= cfg_data_i[imuw_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain: a stage moves on when the next one is empty or moving
  always_comb begin
    adv2    = v2_q && (!emit2_q || !out_valid_q || result_o.ready);
    s2_free = !v2_q || adv2;
    adv1    = v1_q && s2_free;
    s1_free = !v1_q || adv1;
    adv0    = v0_q && s1_free;
    s0_free = !v0_q || adv0;
    in_acc  = sample_i.valid && s0_free;
  end

  assign sample_i.ready = s0_free;

  assign cur[0] = sample_i.accel_x;
  assign cur[1] = sample_i.accel_y;
  assign cur[2] = sample_i.accel_z;
  assign cur[3] = sample_i.gyro_x;
  assign cur[4] = sample_i.gyro_y;
  assign cur[5] = sample_i.gyro_z;

  // fill count, stride counter and ring pointer, settled at acceptance
  always_comb begin
    ctl_in.has_diff  = (seen_q != '0);
    ctl_in.old_valid = (seen_q == SeenW'(WINDOW_SAMPLES));
    seen_d     = ctl_in.old_valid ? seen_q : seen_q + SeenW'(1);
    full       = (seen_d == SeenW'(WINDOW_SAMPLES));
    stride_inc = stride_q + imuw_pkg::STRIDE_W'(1);
    ctl_in.emit = full && (stride_inc >= stride_cfg_q);
    stride_d   = stride_q;
    if (full) begin
      stride_d = ctl_in.emit ? '0 : stride_inc;
    end
    ptr_d = ptr_q;
    if (ctl_in.has_diff) begin
      ptr_d = (ptr_q == PtrW'(RingDepth - 1)) ? '0 : ptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      stride_q <= '0;
      ptr_q    <= '0;
      v0_q     <= 1'b0;
    end else begin
      v0_q <= in_acc || (v0_q && !adv0);
      if (in_acc) begin
        seen_q   <= seen_d;
        stride_q <= stride_d;
        ptr_q    <= ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctl0_q <= ctl_in;
      ptr0_q <= ptr_q;
      for (int unsigned a = 0; a < imuw_pkg::AXIS_COUNT; a++) begin
        prev_q[a] <= cur[a];
      end
    end
  end

  for (genvar g = 0; g < imuw_pkg::AXIS_COUNT; g++) begin : g_lane
    imuw_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (in_acc),
      .cur_i  (cur[g]),
      .prev_i (prev_q[g]),
      .sq_o   (sq0[g])
    );
  end

  imuw_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (adv0),
    .sq_i     (sq0),
    .ctl_i    (ctl0_q),
    .sum_o    (sum0),
    .energy_o (energy1),
    .ctl_o    (ctl1)
  );

  imuw_ring #(
    .DEPTH  (RingDepth),
    .ADDR_W (PtrW),
    .DATA_W (imuw_pkg::ENERGY_W)
  ) u_ring (
    .clk_i   (clk_i),
    .en_i    (adv0),
    .we_i    (ctl0_q.has_diff),
    .addr_i  (ptr0_q),
    .wdata_i (sum0),
    .rdata_o (old1)
  );

  // running total: drop the replaced energy, add the new one
  always_comb begin
    total_d = total_q;
    if (ctl1.has_diff) begin
      total_d = total_q + TotW'(energy1)
              - (ctl1.old_valid ? TotW'(old1) : TotW'(0));
    end
  end

  assign tot_cmp = CmpW'(total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      emit2_q     <= 1'b0;
    end else begin
      v1_q        <= adv0 || (v1_q && !adv1);
      v2_q        <= adv1 || (v2_q && !adv2);
      out_valid_q <= (adv2 && emit2_q) || (out_valid_q && !result_o.ready);
      if (adv1) begin
        total_q <= total_d;
        emit2_q <= ctl1.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && emit2_q) begin
      out_total_q  <= tot_cmp[imuw_pkg::TOTAL_W-1:0];
      out_moving_q <= (tot_cmp >= CmpW'(floor_q));
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.motion_total = out_total_q;
  assign result_o.moving       = out_moving_q;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrW'(RingDepth - 1))
    else $error("ring pointer out of range");

  a_stride_idle_until_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q != SeenW'(WINDOW_SAMPLES)) |-> (stride_q == '0))
    else $error("stride counter moved before the window filled");

  a_emit_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv2 && emit2_q) |-> (seen_q == SeenW'(WINDOW_SAMPLES)))
    else $error("result produced before the window filled");

  a_old_needs_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && ctl1.old_valid) |-> ctl1.has_diff)
    else $error("ring slot replaced without a step energy");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the imu window motion energy gate: drives samples with random gaps,
// predicts every window evaluation and checks each result transaction against it
// depends on imuw_pkg, imuw_sample_if, imuw_result_if and the gate's top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [imuw_pkg::SAMPLE_W-1:0] axis_t;
  typedef axis_t imu_sample_t [imuw_pkg::AXIS_COUNT];

  typedef struct {
    logic [imuw_pkg::TOTAL_W-1:0] motion_total;
    logic                         moving;
  } motion_eval_t;

  typedef enum int { SEG_FULL, SEG_DRIFT, SEG_STILL, SEG_EXTREME } seg_kind_e;

  localparam int unsigned  RING_SLOTS    = imuw_pkg::WINDOW_SAMPLES - 1;
  localparam int unsigned  TARGET_ITEMS  = 1050;
  localparam int unsigned  IDLE_LIMIT    = 4000;
  localparam int unsigned  SETTLE_CYCLES = 8;
  localparam axis_t        AXIS_MAX      = 16'sh7FFF;
  localparam axis_t        AXIS_MIN      = 16'sh8000;
  localparam logic [imuw_pkg::TOTAL_W-1:0] PEAK_TOTAL = 42'd2551132717650;

  // tracks the window energy and the evaluations that are still owed
  class energy_gate_tracker;
    logic [imuw_pkg::TOTAL_W-1:0]  floor_q    = imuw_pkg::FLOOR_RESET;
    logic [imuw_pkg::STRIDE_W-1:0] stride_q   = imuw_pkg::STRIDE_RESET;
    axis_t                         last_axes [imuw_pkg::AXIS_COUNT] = '{default: '0};
    logic [imuw_pkg::ENERGY_W-1:0] step_ring [RING_SLOTS] = '{default: '0};
    logic [imuw_pkg::TOTAL_W-1:0]  total      = '0;
    int unsigned                   slot       = 0;
    int unsigned                   seen       = 0;
    logic [imuw_pkg::STRIDE_W-1:0] since_eval = '0;
    motion_eval_t                  pending_evals [$];
    int unsigned                   errors     = 0;

    function void write_reg(logic [imuw_pkg::CFG_IDX_W-1:0] idx,
                            logic [imuw_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        imuw_pkg::CFG_ENERGY_LIMIT: floor_q = data[imuw_pkg::TOTAL_W-1:0];
        imuw_pkg::CFG_EVAL_STRIDE:  stride_q = data[imuw_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function void absorb_sample(imu_sample_t s);
      longint       energy;
      int           diff;
      motion_eval_t ev;
      // the very first sample has no neighbour to differ from
      if (seen > 0) begin
        energy = 0;
        for (int a = 0; a < imuw_pkg::AXIS_COUNT; a++) begin
          diff = int'(s[a]) - int'(last_axes[a]);
          energy += longint'(diff) * longint'(diff);
        end
        total = total - step_ring[slot] + energy[imuw_pkg::ENERGY_W-1:0];
        step_ring[slot] = energy[imuw_pkg::ENERGY_W-1:0];
        slot = (slot + 1) % RING_SLOTS;
      end
      last_axes = s;
      if (seen < imuw_pkg::WINDOW_SAMPLES) seen++;
      if (seen < imuw_pkg::WINDOW_SAMPLES) return;
      // a stride of zero still evaluates on every sample
      since_eval = since_eval + 1'b1;
      if (since_eval < stride_q) return;
      since_eval = '0;
      ev.motion_total = total;
      ev.moving       = (total >= floor_q);
      pending_evals.push_back(ev);
    endfunction

    function void match_eval(logic [imuw_pkg::TOTAL_W-1:0] got_total, logic got_moving);
      motion_eval_t want;
      if (pending_evals.size() == 0) begin
        $error("unexpected result transaction: motion_total %0d moving %0b",
               got_total, got_moving);
        errors++;
        return;
      end
      want = pending_evals.pop_front();
      if (got_total !== want.motion_total) begin
        $error("motion_total: expected %0d, got %0d", want.motion_total, got_total);
        errors++;
      end
      if (got_moving !== want.moving) begin
        $error("moving: expected %0b, got %0b", want.moving, got_moving);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [imuw_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [imuw_pkg::CFG_DATA_W-1:0] cfg_data;

  imuw_sample_if sample_ch ();
  imuw_result_if result_ch ();

  energy_gate_tracker tracker;
  bit                 steady_flow  = 1'b0;
  int unsigned        items_sent   = 0;
  int unsigned        quiet_cycles = 0;
  imu_sample_t        last_sent    = '{default: '0};
  seg_kind_e          seg_kind     = SEG_FULL;
  int unsigned        seg_left     = 0;
  int unsigned        drift_span   = 1;

  imu_window_motion_energy_gate_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    result_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      tracker.match_eval(result_ch.motion_total, result_ch.moving);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input imu_sample_t s);
    while (!steady_flow && $urandom_range(0, 99) < 13) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.accel_x <= s[0];
    sample_ch.accel_y <= s[1];
    sample_ch.accel_z <= s[2];
    sample_ch.gyro_x  <= s[3];
    sample_ch.gyro_y  <= s[4];
    sample_ch.gyro_z  <= s[5];
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    tracker.absorb_sample(s);
    last_sent = s;
    items_sent++;
  endtask

  // segments of full noise, slow drift, standstill and rail values
  task automatic make_random(output imu_sample_t s);
    if (seg_left == 0) begin
      seg_kind   = seg_kind_e'($urandom_range(0, 3));
      seg_left   = $urandom_range(1, 40);
      drift_span = 1 << $urandom_range(0, 13);
    end
    seg_left--;
    for (int a = 0; a < imuw_pkg::AXIS_COUNT; a++) begin
      case (seg_kind)
        SEG_FULL:  s[a] = axis_t'($urandom);
        SEG_DRIFT: s[a] = last_sent[a] + axis_t'($urandom_range(0, 2 * drift_span) - drift_span);
        SEG_STILL: s[a] = last_sent[a];
        default: begin
          case ($urandom_range(0, 3))
            0:       s[a] = AXIS_MAX;
            1:       s[a] = AXIS_MIN;
            2:       s[a] = '0;
            default: s[a] = -1;
          endcase
        end
      endcase
    end
  endtask

  task automatic send_random(input int unsigned count);
    imu_sample_t s;
    repeat (count) begin
      make_random(s);
      send_sample(s);
    end
  endtask

  task automatic write_config(input logic [imuw_pkg::TOTAL_W-1:0] floor_v,
                              input logic [imuw_pkg::STRIDE_W-1:0] stride_v);
    logic [imuw_pkg::CFG_DATA_W-1:0] stride_word;
    // junk above the stride field must be ignored
    stride_word = imuw_pkg::CFG_DATA_W'({$urandom, $urandom});
    stride_word[imuw_pkg::STRIDE_W-1:0] = stride_v;
    cfg_we   <= 1'b1;
    cfg_idx  <= imuw_pkg::CFG_ENERGY_LIMIT;
    cfg_data <= floor_v;
    @(posedge clk_i);
    tracker.write_reg(imuw_pkg::CFG_ENERGY_LIMIT, floor_v);
    cfg_idx  <= imuw_pkg::CFG_EVAL_STRIDE;
    cfg_data <= stride_word;
    @(posedge clk_i);
    tracker.write_reg(imuw_pkg::CFG_EVAL_STRIDE, stride_word);
    cfg_we <= 1'b0;
  endtask

  // samples that yield no result may still be in flight, so wait out the pipeline
  task automatic drain_and_settle();
    sample_ch.valid <= 1'b0;
    while (tracker.pending_evals.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    imu_sample_t s;
    tracker = new();
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    result_ch.ready   = 1'b0;
    sample_ch.valid   = 1'b0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    sample_ch.gyro_x  = '0;
    sample_ch.gyro_y  = '0;
    sample_ch.gyro_z  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window fill under reset settings, full-scale steps on each axis
    s = '{default: '0};      send_sample(s);
    s = '{default: AXIS_MAX}; send_sample(s);
    s = '{default: AXIS_MIN}; send_sample(s);
    s = '{default: AXIS_MAX}; send_sample(s);
    s = '{default: -1};       send_sample(s);
    for (int a = 0; a < imuw_pkg::AXIS_COUNT; a++) begin
      s = '{default: '0};
      s[a] = AXIS_MIN;
      send_sample(s);
      s[a] = AXIS_MAX;
      send_sample(s);
    end
    for (int a = 0; a < imuw_pkg::AXIS_COUNT; a++) s[a] = (a % 2) ? 16'sh5555 : 16'shAAAA;
    send_sample(s);
    for (int a = 0; a < imuw_pkg::AXIS_COUNT; a++) s[a] = (a % 2) ? 16'shAAAA : 16'sh5555;
    send_sample(s);
    s = '{default: '0}; send_sample(s);
    s = '{default: 1};  send_sample(s);
    send_random(180);
    drain_and_settle();

    // zero floor, every sample evaluated, no gaps on either side
    steady_flow = 1'b1;
    write_config('0, imuw_pkg::STRIDE_W'(1));
    send_random(150);
    drain_and_settle();
    steady_flow = 1'b0;

    write_config({imuw_pkg::TOTAL_W{1'b1}}, '0);
    send_random(100);
    drain_and_settle();

    // a repeated sample adds zero energy, so the next total lands exactly on the floor
    write_config(tracker.total - tracker.step_ring[tracker.slot], imuw_pkg::STRIDE_W'(1));
    send_sample(last_sent);
    send_random(99);
    drain_and_settle();

    // rail-to-rail swings on every axis push the total to its largest value
    write_config(PEAK_TOTAL, imuw_pkg::STRIDE_W'(1));
    for (int i = 0; i < 110; i++) begin
      s = '{default: (i % 2) ? AXIS_MIN : AXIS_MAX};
      send_sample(s);
    end
    drain_and_settle();

    write_config(imuw_pkg::TOTAL_W'({$urandom, $urandom} >> $urandom_range(22, 63)),
                 {imuw_pkg::STRIDE_W{1'b1}});
    send_random(300);
    drain_and_settle();

    while (items_sent < TARGET_ITEMS) begin
      write_config(imuw_pkg::TOTAL_W'({$urandom, $urandom} >> $urandom_range(22, 63)),
                   imuw_pkg::STRIDE_W'($urandom_range(1, 12)));
      send_random($urandom_range(60, 120));
      drain_and_settle();
    end

    if (tracker.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
